/* sv/pm4rp_pkg.sv */
// shared types and constants of the ring packet parser
`default_nettype none
package pm4rp_pkg;

  // ring index width and fixed output widths
  localparam int RING_INDEX_BITS = 16;
  localparam int BATCH_COUNT_BITS = 17;

  // header types
  localparam logic [1:0] TYPE_DESYNC = 2'd1;
  localparam logic [1:0] TYPE_FILLER = 2'd2;
  localparam logic [1:0] TYPE_THREE  = 2'd3;

  // swap opcode and minimum payload
  localparam logic [6:0]  SWAP_OPCODE    = 7'h64;
  localparam logic [14:0] SWAP_MIN_COUNT = 15'd4;

  // record kinds
  localparam logic [1:0] KIND_PACKET = 2'd0;
  localparam logic [1:0] KIND_DESYNC = 2'd1;
  localparam logic [1:0] KIND_DRAIN  = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       ptype;
    logic [6:0]       opcode;
    logic [14:0]      payload;
    logic             swap_seen;
    logic [3:0][31:0] swap_words;
    logic [15:0]      read_index;
    logic [15:0]      consumed;
    logic             last;
  } record_t;

  // records produced by one input item
  typedef struct packed {
    logic [1:0] count;
    record_t    first;
    record_t    second;
  } push_t;

endpackage
`default_nettype wire

/* sv/pm4rp_parser.sv */
// header parsing, payload skipping and swap capture for one ring word per cycle while accept is high
`default_nettype none
module pm4rp_parser import pm4rp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        accept,
  input  wire logic [31:0] ring_word,
  input  wire logic        batch_end,
  output push_t            push
);

  localparam logic [1:0] PHASE_HEADER  = 2'd0;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
  localparam logic [1:0] PHASE_DROP    = 2'd3;

  logic [3:0]                  ring_size_log2;
  logic [RING_INDEX_BITS-1:0]  read_pointer, read_pointer_next;
  logic [1:0]                  parse_phase, parse_phase_next;
  logic [14:0]                 words_remaining, words_remaining_next;
  logic [2:0]                  payload_position, payload_position_next;
  logic [1:0]                  held_type, held_type_next;
  logic [6:0]                  held_opcode, held_opcode_next;
  logic [14:0]                 held_count, held_count_next;
  logic [3:0][31:0]            captured, captured_next;
  logic [BATCH_COUNT_BITS-1:0] batch_word_count, batch_word_count_next;

  logic [RING_INDEX_BITS-1:0]  mask;
  logic [4:0]                  exponent;
  logic [BATCH_COUNT_BITS-1:0] batch_inc;
  logic [1:0]                  hdr_type;
  logic                        held_swap;
  logic                        pkt_valid;
  record_t                     pkt_rec;
  record_t                     drain_rec;
  logic [31:0]                 rp_wide;
  logic [31:0]                 cons_wide;

  // ring mask from the size exponent, capped at the index width
  always_comb begin
    exponent = 5'(ring_size_log2) + 5'd1;
    if (32'(exponent) > RING_INDEX_BITS) begin
      exponent = 5'(RING_INDEX_BITS);
    end
    mask = ~({RING_INDEX_BITS{1'b1}} << exponent);
  end

  assign hdr_type  = ring_word[31:30];
  assign held_swap = (held_type == TYPE_THREE) && (held_opcode == SWAP_OPCODE) &&
                     (held_count >= SWAP_MIN_COUNT);
  assign batch_inc = batch_word_count + 1'b1;

  // next state and packet or desync record
  always_comb begin
    read_pointer_next     = (read_pointer + 1'b1) & mask;
    batch_word_count_next = batch_inc;
    parse_phase_next      = parse_phase;
    words_remaining_next  = words_remaining;
    payload_position_next = payload_position;
    held_type_next        = held_type;
    held_opcode_next      = held_opcode;
    held_count_next       = held_count;
    captured_next         = captured;
    pkt_valid             = 1'b0;
    pkt_rec               = '0;
    case (parse_phase)
      PHASE_HEADER: begin
        if (hdr_type == TYPE_FILLER) begin
          pkt_valid     = 1'b1;
          pkt_rec.kind  = KIND_PACKET;
          pkt_rec.ptype = TYPE_FILLER;
        end else if (hdr_type == TYPE_DESYNC) begin
          pkt_valid        = 1'b1;
          pkt_rec.kind     = KIND_DESYNC;
          pkt_rec.ptype    = TYPE_DESYNC;
          parse_phase_next = PHASE_DROP;
        end else begin
          held_type_next        = hdr_type;
          held_opcode_next      = (hdr_type == TYPE_THREE) ? ring_word[14:8] : 7'd0;
          held_count_next       = {1'b0, ring_word[29:16]} + 15'd1;
          words_remaining_next  = {1'b0, ring_word[29:16]} + 15'd1;
          payload_position_next = 3'd0;
          captured_next         = '0;
          parse_phase_next      = PHASE_PAYLOAD;
        end
      end
      PHASE_PAYLOAD: begin
        if (held_swap && !payload_position[2]) begin
          captured_next[payload_position[1:0]] = ring_word;
        end
        if (!payload_position[2]) begin
          payload_position_next = payload_position + 3'd1;
        end
        words_remaining_next = words_remaining - 15'd1;
        if (words_remaining_next == 15'd0) begin
          pkt_valid          = 1'b1;
          pkt_rec.kind       = KIND_PACKET;
          pkt_rec.ptype      = held_type;
          pkt_rec.opcode     = held_opcode;
          pkt_rec.payload    = held_count;
          pkt_rec.swap_seen  = held_swap;
          pkt_rec.swap_words = held_swap ? captured_next : '0;
          parse_phase_next   = PHASE_HEADER;
        end
      end
      default: begin
        // dropping to batch end
      end
    endcase
    if (batch_end) begin
      batch_word_count_next = '0;
      if (parse_phase_next[1]) begin
        parse_phase_next = PHASE_HEADER;
      end
    end
  end

  // drain record at batch end
  always_comb begin
    rp_wide              = 32'(read_pointer_next);
    cons_wide            = 32'(batch_inc) & 32'(mask);
    drain_rec            = '0;
    drain_rec.kind       = KIND_DRAIN;
    drain_rec.read_index = rp_wide[15:0];
    drain_rec.consumed   = cons_wide[15:0];
    drain_rec.last       = 1'b1;
  end

  // order the records of this item, last flag on the final one
  always_comb begin
    push = '0;
    if (pkt_valid && batch_end) begin
      push.count  = 2'd2;
      push.first  = pkt_rec;
      push.second = drain_rec;
    end else if (pkt_valid) begin
      push.count      = 2'd1;
      push.first      = pkt_rec;
      push.first.last = 1'b1;
    end else if (batch_end) begin
      push.count = 2'd1;
      push.first = drain_rec;
    end
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  // state registers; a register write restarts the ring
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      read_pointer     <= '0;
      parse_phase      <= PHASE_HEADER;
      words_remaining  <= '0;
      payload_position <= '0;
      held_type        <= '0;
      held_opcode      <= '0;
      held_count       <= '0;
      captured         <= '0;
      batch_word_count <= '0;
    end else if (accept) begin
      read_pointer     <= read_pointer_next;
      parse_phase      <= parse_phase_next;
      words_remaining  <= words_remaining_next;
      payload_position <= payload_position_next;
      held_type        <= held_type_next;
      held_opcode      <= held_opcode_next;
      held_count       <= held_count_next;
      captured         <= captured_next;
      batch_word_count <= batch_word_count_next;
    end
  end

  // ring size register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size_log2 <= '0;
    end else if (cfg_write) begin
      ring_size_log2 <= cfg_data;
    end
  end

endmodule
`default_nettype wire

/* sv/pm4rp_out_queue.sv */
// four-entry result queue taking up to two records per cycle
`default_nettype none
module pm4rp_out_queue import pm4rp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output record_t   head
);

  record_t    entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign head      = entries[rd_ptr];
  assign count_next = count + 3'(push.count) - 3'(pop);

  // record storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

/* sv/pm4_ring_packet_parser.sv */
// top level of the ring packet parser
// Usage:
//   Ring dwords enter on the input channel (in_valid/in_ready) with ring_word
//   and batch_end, one item per cycle when the output side keeps up.
//   Each item yields zero, one or two result items on the output channel
//   (out_valid/out_ready): a packet or desync record, a drain record at batch
//   end, or both, the final one of an item marked by last.
//   With the queue empty, the first result of an item is shown in the cycle
//   after the item is accepted; a second result follows the cycle after the
//   first is taken.
//   Throughput: one item per cycle while in_ready is high; the parser state
//   updates in one pass per word, and the four-entry result queue keeps
//   in_ready high while it has room for two records.
//   When the receiver stalls the queue fills and in_ready falls once fewer
//   than two entries are free; nothing is lost.
//   Configuration: cfg_valid/cfg_ready/cfg_data writes ring_size_log2 and
//   restarts the ring state; cfg_ready is always high.
//   Reset (rst, synchronous): ring size exponent, read pointer, batch count
//   and parse state go to zero and the queue empties.
`default_nettype none
module pm4_ring_packet_parser import pm4rp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] ring_word,
  input  wire logic        batch_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       record_kind,
  output logic [1:0]       packet_type,
  output logic [6:0]       packet_opcode,
  output logic [14:0]      payload_words,
  output logic             swap_seen,
  output logic [31:0]      swap_magic,
  output logic [31:0]      swap_frontbuffer,
  output logic [31:0]      swap_width,
  output logic [31:0]      swap_height,
  output logic [15:0]      read_index,
  output logic [15:0]      consumed_words,
  output logic             last
);

  push_t   push;
  record_t head;
  logic    room;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;

  // per-word parser
  pm4rp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (in_valid && room),
    .ring_word (ring_word),
    .batch_end (batch_end),
    .push      (push)
  );

  // result queue
  pm4rp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // result fields
  assign record_kind      = head.kind;
  assign packet_type      = head.ptype;
  assign packet_opcode    = head.opcode;
  assign payload_words    = head.payload;
  assign swap_seen        = head.swap_seen;
  assign swap_magic       = head.swap_words[0];
  assign swap_frontbuffer = head.swap_words[1];
  assign swap_width       = head.swap_words[2];
  assign swap_height      = head.swap_words[3];
  assign read_index       = head.read_index;
  assign consumed_words   = head.consumed;
  assign last             = head.last;

endmodule
`default_nettype wire
